// ===== rtl/hcpm_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hcpm_pkg: shared constants and fp32/bf16 arithmetic
// Round-to-nearest-even fp32 multiply and add with subnormals, and the
// fp32 to bf16 conversion used by the post-mix pipeline.
// ---------------------------------------------------------------------------
package hcpm_pkg;

   localparam int MaxStreams = 4;
   localparam int IndexWidth = 5;
   localparam int ReqDataWidth = 120;
   localparam int RspDataWidth = 64;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_MIX  = 1'b1;

   localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
   localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

   // Normalize and round: value is (m / 2^47) * 2^(e - 127); m is nonzero
   function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
                                              input logic [47:0] m);
      logic [5:0] lz;
      logic found;
      logic [47:0] mn;
      logic signed [11:0] en;
      logic [11:0] sh;
      logic st;
      logic [23:0] mant;
      logic g;
      logic [7:0] ef;
      logic [30:0] mag;
      lz = 6'd0;
      found = 1'b0;
      for (int i = 47; i >= 0; i--) begin
         if (!found && m[i]) begin
            lz = 6'(47 - i);
            found = 1'b1;
         end
      end
      mn = m << lz;
      en = e - $signed({6'd0, lz});
      // Denormalize into the subnormal range
      if (en <= 12'sd0) begin
         sh = 12'(12'sd1 - en);
         if (sh >= 12'd48) begin
            st = |mn;
            mn = 48'd0;
         end else begin
            st = |(mn & ((48'd1 << sh) - 48'd1));
            mn = mn >> sh;
         end
         mn[0] = mn[0] | st;
         en = 12'sd0;
      end
      if (en >= 12'sd255) begin
         return {s, 8'hFF, 23'd0};
      end
      mant = mn[47:24];
      g = mn[23];
      st = |mn[22:0];
      ef = mant[23] ? en[7:0] : 8'd0;
      mag = {ef, mant[22:0]} + 31'(g && (st || mant[0]));
      return {s, mag};
   endfunction

   function automatic logic [31:0] fp32_mul(input logic [31:0] a, input logic [31:0] b);
      logic anan, bnan, ainf, binf, azero, bzero, s;
      logic [7:0] ea, eb;
      logic [23:0] ma, mb;
      logic [47:0] p;
      logic signed [11:0] e;
      anan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      bnan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      ainf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      binf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      azero = (a[30:0] == 31'd0);
      bzero = (b[30:0] == 31'd0);
      s = a[31] ^ b[31];
      if (anan) return a | QUIET_BIT;
      if (bnan) return b | QUIET_BIT;
      if (ainf || binf) begin
         if (azero || bzero) return QNAN_DEFAULT;
         return {s, 8'hFF, 23'd0};
      end
      if (azero || bzero) return {s, 31'd0};
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma = {a[30:23] != 8'd0, a[22:0]};
      mb = {b[30:23] != 8'd0, b[22:0]};
      p = 48'(ma) * 48'(mb);
      e = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126;
      return round_pack(s, e, p);
   endfunction

   function automatic logic [31:0] fp32_add(input logic [31:0] a, input logic [31:0] b);
      logic anan, bnan, ainf, binf, azero, bzero;
      logic [31:0] big, sml;
      logic [7:0] eb, es, d;
      logic [47:0] mb, ms, sum;
      logic st;
      anan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      bnan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      ainf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      binf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      azero = (a[30:0] == 31'd0);
      bzero = (b[30:0] == 31'd0);
      if (anan) return a | QUIET_BIT;
      if (bnan) return b | QUIET_BIT;
      if (ainf && binf) begin
         if (a[31] != b[31]) return QNAN_DEFAULT;
         return a;
      end
      if (ainf) return a;
      if (binf) return b;
      if (azero && bzero) return {a[31] & b[31], 31'd0};
      if (azero) return b;
      if (bzero) return a;
      // Order by magnitude, align the smaller operand with sticky jam
      if (a[30:0] >= b[30:0]) begin
         big = a;
         sml = b;
      end else begin
         big = b;
         sml = a;
      end
      eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      d = eb - es;
      mb = {1'b0, big[30:23] != 8'd0, big[22:0], 23'd0};
      ms = {1'b0, sml[30:23] != 8'd0, sml[22:0], 23'd0};
      if (d >= 8'd48) begin
         st = |ms;
         ms = 48'd0;
      end else begin
         st = |(ms & ((48'd1 << d) - 48'd1));
         ms = ms >> d;
      end
      ms[0] = ms[0] | st;
      sum = (big[31] != sml[31]) ? (mb - ms) : (mb + ms);
      if (sum == 48'd0) return 32'd0;
      return round_pack(big[31], $signed({4'd0, eb}) + 12'sd1, sum);
   endfunction

   function automatic logic [15:0] fp32_to_bf16(input logic [31:0] b);
      logic [31:0] t;
      if ((b[30:23] == 8'hFF) && (b[22:0] != 23'd0)) return b[31:16] | 16'h0040;
      t = b + 32'h0000_7FFF + {31'd0, b[16]};
      return t[31:16];
   endfunction

endpackage

// ===== rtl/hcpm_lane.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hcpm_lane: one output stream of the post mix
// Products in the first stage, one fp32 add per stage after it in stream
// order, then bf16 rounding into the output register.
// ---------------------------------------------------------------------------
module hcpm_lane #(
   parameter int STREAMS = 4,
   localparam int NST = STREAMS + 2
) (
   input  logic                     clock,
   input  logic [NST-1:0]           stage_en,
   input  logic [31:0]              scale_coef,
   input  logic [STREAMS-1:0][31:0] mix_coef,
   input  logic [STREAMS-1:0][15:0] res_val,
   input  logic [15:0]              layer_val,
   output logic [15:0]              mix_out
);

   logic [31:0] acc_ff [STREAMS+1];
   logic [STREAMS-1:0][31:0] prod_ff [STREAMS];
   logic [15:0] out_ff;

   // Form all products of the column
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         acc_ff[0] <= hcpm_pkg::fp32_mul(scale_coef, {layer_val, 16'd0});
         for (int i = 0; i < STREAMS; i++) begin
            prod_ff[0][i] <= hcpm_pkg::fp32_mul(mix_coef[i], {res_val[i], 16'd0});
         end
      end
   end

   // Accumulate one product per stage
   for (genvar k = 1; k <= STREAMS; k++) begin : g_add
      always_ff @(posedge clock) begin
         if (stage_en[k]) begin
            acc_ff[k] <= hcpm_pkg::fp32_add(acc_ff[k-1], prod_ff[k-1][k-1]);
         end
      end
      if (k < STREAMS) begin : g_carry
         always_ff @(posedge clock) begin
            if (stage_en[k]) begin
               prod_ff[k] <= prod_ff[k-1];
            end
         end
      end
   end

   // Round to bf16
   always_ff @(posedge clock) begin
      if (stage_en[NST-1]) begin
         out_ff <= hcpm_pkg::fp32_to_bf16(acc_ff[STREAMS]);
      end
   end

   assign mix_out = out_ff;

endmodule

// ===== rtl/hyper_connection_post_mix.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hyper_connection_post_mix: per-token hyper-connection post mixing
// Throughput: one word per cycle while rsp_tready does not stall the output;
// products, STREAMS add stages and bf16 rounding are each one pipeline stage.
// Load words take effect at once.
// Reset clears the stage valid bits; the coefficient store is not reset.
// ---------------------------------------------------------------------------
module hyper_connection_post_mix #(
   parameter int STREAMS = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // coef_index[4:0], coef_bits[36:5], res_0[52:37], res_1[68:53],
   // res_2[84:69], res_3[100:85], layer_val[116:101], zero pad
   input  logic [119:0] req_tdata,
   // opcode[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_0[15:0], out_1[31:16], out_2[47:32], out_3[63:48]
   output logic [63:0]  rsp_tdata
);

   localparam int NST = STREAMS + 2;
   localparam int SLOTS = STREAMS * STREAMS + STREAMS;

   logic [31:0] coef_ff [SLOTS];
   logic [NST-1:0] valid_ff;
   logic [NST-1:0] valid_in;
   logic [NST-1:0] stage_rdy;
   logic req_acc;
   logic [4:0] coef_index;
   logic [31:0] coef_bits;
   logic [STREAMS-1:0][15:0] res_val;
   logic [15:0] layer_val;
   logic [15:0] lane_out [STREAMS];

   // Unpack the request word
   assign coef_index = req_tdata[4:0];
   assign coef_bits  = req_tdata[36:5];
   assign layer_val  = req_tdata[116:101];
   for (genvar i = 0; i < STREAMS; i++) begin : g_res
      assign res_val[i] = req_tdata[37 + 16*i +: 16];
   end

   // Stage ready: a stage moves when empty or when its successor moves
   always_comb begin
      stage_rdy[NST-1] = !valid_ff[NST-1] || rsp_tready;
      for (int k = NST - 2; k >= 0; k--) begin
         stage_rdy[k] = !valid_ff[k] || stage_rdy[k+1];
      end
   end

   assign req_tready = stage_rdy[0];
   assign req_acc = req_tvalid && req_tready;

   // Advance valid bits
   always_comb begin
      valid_in[0] = req_acc && (req_tuser == hcpm_pkg::OP_MIX);
      for (int k = 1; k < NST; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (stage_rdy[k]) valid_ff[k] <= valid_in[k];
         end
      end
   end

   // Load one coefficient; out-of-range slots are dropped
   always_ff @(posedge clock) begin
      if (req_acc && (req_tuser == hcpm_pkg::OP_LOAD) && (32'(coef_index) < SLOTS)) begin
         coef_ff[coef_index] <= coef_bits;
      end
   end

   for (genvar o = 0; o < STREAMS; o++) begin : g_lane
      logic [STREAMS-1:0][31:0] mix_coef;
      for (genvar i = 0; i < STREAMS; i++) begin : g_col
         assign mix_coef[i] = coef_ff[i*STREAMS + o];
      end
      hcpm_lane #(.STREAMS(STREAMS)) u_lane (
         .clock      (clock),
         .stage_en   (stage_rdy),
         .scale_coef (coef_ff[STREAMS*STREAMS + o]),
         .mix_coef   (mix_coef),
         .res_val    (res_val),
         .layer_val  (layer_val),
         .mix_out    (lane_out[o])
      );
   end

   // Drive the response word, unused streams zero
   always_comb begin
      rsp_tdata = '0;
      for (int o = 0; o < STREAMS; o++) begin
         rsp_tdata[16*o +: 16] = lane_out[o];
      end
   end

   assign rsp_tvalid = valid_ff[NST-1];

endmodule

// ===== rtl/hcpm_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hcpm_checker: port-level checks for the post mix
// Watches the response side for reset, stall and unused-stream behavior.
// ---------------------------------------------------------------------------
module hcpm_checker #(
   parameter int STREAMS = 4
) (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [63:0]  rsp_tdata
);

   // Held response stays valid
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // Held response keeps its word
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // No response right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

   // With two or fewer streams, the upper two stream slots read zero
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (STREAMS > 2) || (rsp_tdata[63:32] == 32'd0))
      else $error("unused stream not zero");

   // Input stalls only behind a stalled response
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled with free output");

endmodule

bind hyper_connection_post_mix hcpm_checker #(.STREAMS(STREAMS)) u_hcpm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
